### rtl/qbt_pkg.sv
// ----------------------------------------------------------------------------
// qbt_pkg
// Shared types and constants for the quoted/bracketed line tokenizer.
// ----------------------------------------------------------------------------
package qbt_pkg;

   localparam int TOKEN_CHARS_DEF = 32;

   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;

   typedef enum logic [2:0] {
      LM_NORMAL  = 3'd0,
      LM_QUOTED  = 3'd1,
      LM_QPEND   = 3'd2,
      LM_BRACKET = 3'd3,
      LM_COMMENT = 3'd4
   } lex_mode_type;

   typedef enum logic [2:0] {
      RP_IDLE,
      RP_OPEN,
      RP_BODY,
      RP_CLOSE,
      RP_EMPTY
   } replay_state_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       char_valid;
      logic       token_last;
      logic       overflowed;
   } rsp_type;

   // token hand-off from the lexer to the replay sequencer
   typedef struct packed {
      logic start;
      logic bracketed;
      logic allow_empty;
      logic overflow;
   } launch_type;

   // one result slot in flight through the buffer read
   typedef struct packed {
      logic       from_mem;
      logic [7:0] ch;
      logic       valid;
      logic       last;
      logic       ovf;
   } slot_type;

endpackage

### rtl/quoted_bracket_tokenizer.sv
// ----------------------------------------------------------------------------
// quoted_bracket_tokenizer
// Line tokenizer with quoted spans, bracketed spans and comments.
// ----------------------------------------------------------------------------
// While a token is being collected the block takes one byte per cycle and
// writes it into a TOKEN_CHARS-entry buffer memory. When a token finishes
// (whitespace, closing bracket, the byte after a closing quote, or end of
// line), the input stalls and the token is read back out of that memory
// through its registered read port, one result per cycle while the result
// queue has room, plus one result each for the brackets of a bracketed
// token. A byte that finishes a token and also starts the next one is held
// and written to the buffer once the replay is done. Results sit in a
// two-entry queue, so the next bytes are taken while the last results
// still wait. Reset is synchronous.
// ----------------------------------------------------------------------------
module quoted_bracket_tokenizer #(
   parameter int TOKEN_CHARS = qbt_pkg::TOKEN_CHARS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  qbt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output qbt_pkg::rsp_type rsp_data
);
   import qbt_pkg::*;

   localparam int LEN_W = $clog2(TOKEN_CHARS+1);
   localparam int IDX_W = $clog2(TOKEN_CHARS);

   lex_mode_type     mode_ff, mode_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic             wpend_ff, wpend_in;
   logic [7:0]       wchar_ff, wchar_in;

   logic             acc;
   logic [7:0]       c;
   logic             do_emit, emit_br, emit_allow, do_app;
   logic [7:0]       app_ch;
   logic [LEN_W-1:0] base_len;
   logic             base_ovf;
   logic             fits;

   launch_type       launch;
   logic             busy;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [7:0]       rd_data;

   function automatic logic is_space(input logic [7:0] ch);
      return (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
   endfunction

   function automatic lex_mode_type from_normal(input logic [7:0] ch);
      lex_mode_type m;
      m = LM_NORMAL;
      if (ch == CH_SEMI) begin
         m = LM_COMMENT;
      end else if (ch == CH_QUOTE) begin
         m = LM_QUOTED;
      end else if (ch == CH_LBRACK) begin
         m = LM_BRACKET;
      end
      return m;
   endfunction

   assign acc       = req_valid && !req_stall;
   assign c         = req_data.char_in;
   assign req_stall = busy || wpend_ff;

   // next mode
   always_comb begin
      mode_in = mode_ff;
      if (acc) begin
         if (req_data.line_end) begin
            mode_in = LM_NORMAL;
         end else begin
            case (mode_ff)
               LM_QUOTED:  mode_in = (c == CH_QUOTE) ? LM_QPEND : LM_QUOTED;
               LM_QPEND:   mode_in = (c == CH_QUOTE) ? LM_QUOTED : from_normal(c);
               LM_BRACKET: mode_in = (c == CH_RBRACK) ? LM_NORMAL : LM_BRACKET;
               LM_COMMENT: mode_in = LM_COMMENT;
               default:    mode_in = from_normal(c);
            endcase
         end
      end
   end

   // actions for the byte at hand
   always_comb begin
      do_emit    = 1'b0;
      emit_br    = 1'b0;
      emit_allow = 1'b0;
      do_app     = 1'b0;
      app_ch     = c;
      if (req_data.line_end) begin
         do_emit    = 1'b1;
         emit_allow = (mode_ff == LM_QPEND);
      end else begin
         case (mode_ff)
            LM_QUOTED: begin
               do_app = (c != CH_QUOTE);
            end
            LM_QPEND: begin
               if (c == CH_QUOTE) begin
                  do_app = 1'b1;
                  app_ch = CH_QUOTE;
               end else begin
                  // close the quoted token, then treat the byte as unquoted
                  do_emit    = 1'b1;
                  emit_allow = 1'b1;
                  do_app     = (c != CH_SEMI) && !is_space(c) && (c != CH_LBRACK);
               end
            end
            LM_BRACKET: begin
               if (c == CH_RBRACK) begin
                  do_emit = 1'b1;
                  emit_br = 1'b1;
               end else begin
                  do_app = 1'b1;
               end
            end
            LM_COMMENT: ;
            default: begin
               if (is_space(c)) begin
                  do_emit = (len_ff != '0);
               end else begin
                  do_app = (c != CH_SEMI) && (c != CH_QUOTE) && (c != CH_LBRACK);
               end
            end
         endcase
      end
   end

   assign base_len = do_emit ? '0 : len_ff;
   assign base_ovf = do_emit ? 1'b0 : ovf_ff;
   assign fits     = base_len < LEN_W'(TOKEN_CHARS);

   always_comb begin
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      wpend_in = wpend_ff;
      wchar_in = wchar_ff;
      if (acc) begin
         len_in = base_len;
         ovf_in = base_ovf;
         if (do_app) begin
            if (fits) begin
               len_in = base_len + LEN_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
         // a byte that follows an emitted token waits until the replay is done
         if (do_app && do_emit) begin
            wpend_in = 1'b1;
            wchar_in = app_ch;
         end
      end else if (wpend_ff && !busy) begin
         wpend_in = 1'b0;
      end
   end

   always_comb begin
      launch.start       = acc && do_emit && (emit_br || emit_allow || (len_ff != '0));
      launch.bracketed   = emit_br;
      launch.allow_empty = emit_allow;
      launch.overflow    = ovf_ff;
   end

   always_comb begin
      if (wpend_ff) begin
         wr_en   = !busy;
         wr_addr = '0;
         wr_data = wchar_ff;
      end else begin
         wr_en   = acc && do_app && !do_emit && fits;
         wr_addr = base_len[IDX_W-1:0];
         wr_data = app_ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= LM_NORMAL;
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
         wpend_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
         wpend_ff <= wpend_in;
      end
   end

   always_ff @(posedge clock) begin
      wchar_ff <= wchar_in;
   end

   qbt_tokbuf #(
      .DEPTH (TOKEN_CHARS),
      .IDX_W (IDX_W)
   ) u_tokbuf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   qbt_replay #(
      .TOKEN_CHARS (TOKEN_CHARS)
   ) u_replay (
      .clock      (clock),
      .reset      (reset),
      .launch     (launch),
      .launch_len (len_ff),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   a_pend_len_one: assert property (@(posedge clock) disable iff (reset)
      wpend_ff |-> (len_ff == LEN_W'(1)))
      else $error("deferred byte without length one");

   a_launch_clears_len: assert property (@(posedge clock) disable iff (reset)
      launch.start |=> (len_ff <= LEN_W'(1)) && !ovf_ff)
      else $error("token state not cleared on launch");

endmodule

### rtl/qbt_tokbuf.sv
// ----------------------------------------------------------------------------
// qbt_tokbuf
// Token character buffer: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module qbt_tokbuf #(
   parameter int DEPTH = 32,
   parameter int IDX_W = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [7:0]       wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [7:0]       rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/qbt_replay.sv
// ----------------------------------------------------------------------------
// qbt_replay
// Replays a finished token from the buffer into a two-entry result queue.
// ----------------------------------------------------------------------------
module qbt_replay #(
   parameter int TOKEN_CHARS = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  qbt_pkg::launch_type                      launch,
   input  logic [$clog2(TOKEN_CHARS+1)-1:0]         launch_len,
   output logic                                     rd_en,
   output logic [$clog2(TOKEN_CHARS)-1:0]           rd_addr,
   input  logic [7:0]                               rd_data,
   output logic                                     busy,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output qbt_pkg::rsp_type                         rsp_data
);
   import qbt_pkg::*;

   localparam int LEN_W = $clog2(TOKEN_CHARS+1);
   localparam int IDX_W = $clog2(TOKEN_CHARS);

   replay_state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             bracket_ff, bracket_in;
   logic             ovf_ff, ovf_in;

   logic             inflight_ff;
   slot_type         slot_ff;
   slot_type         slot;
   logic             issue;
   logic             room;
   logic             body_end;

   rsp_type          fifo_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;
   rsp_type          push_data;

   assign pop  = (count_ff != 2'd0) && !rsp_stall;
   assign push = inflight_ff;

   // queue slots plus the read in flight may not exceed two after this pop
   assign room = ((count_ff + 2'(inflight_ff)) < 2'd2) ||
                 (((count_ff + 2'(inflight_ff)) == 2'd2) && pop);

   assign body_end = (LEN_W'(idx_ff) + LEN_W'(1)) == len_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         RP_IDLE: begin
            if (launch.start) begin
               if (launch.bracketed) begin
                  state_in = RP_OPEN;
               end else if (launch_len != '0) begin
                  state_in = RP_BODY;
               end else if (launch.allow_empty) begin
                  state_in = RP_EMPTY;
               end
            end
         end
         RP_OPEN: begin
            if (issue) begin
               state_in = (len_ff != '0) ? RP_BODY : RP_CLOSE;
            end
         end
         RP_BODY: begin
            if (issue && body_end) begin
               state_in = bracket_ff ? RP_CLOSE : RP_IDLE;
            end
         end
         RP_CLOSE, RP_EMPTY: begin
            if (issue) begin
               state_in = RP_IDLE;
            end
         end
         default: state_in = RP_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      issue         = (state_ff != RP_IDLE) && room;
      slot.from_mem = 1'b0;
      slot.ch       = 8'h00;
      slot.valid    = 1'b1;
      slot.last     = 1'b0;
      slot.ovf      = ovf_ff;
      case (state_ff)
         RP_OPEN: begin
            slot.ch = CH_LBRACK;
         end
         RP_BODY: begin
            slot.from_mem = 1'b1;
            slot.last     = !bracket_ff && body_end;
         end
         RP_CLOSE: begin
            slot.ch   = CH_RBRACK;
            slot.last = 1'b1;
         end
         RP_EMPTY: begin
            slot.valid = 1'b0;
            slot.last  = 1'b1;
         end
         default: ;
      endcase
   end

   assign rd_en   = issue && (state_ff == RP_BODY);
   assign rd_addr = idx_ff;
   assign busy    = (state_ff != RP_IDLE);

   always_comb begin
      idx_in     = idx_ff;
      len_in     = len_ff;
      bracket_in = bracket_ff;
      ovf_in     = ovf_ff;
      if (state_ff == RP_IDLE && launch.start) begin
         idx_in     = '0;
         len_in     = launch_len;
         bracket_in = launch.bracketed;
         ovf_in     = launch.overflow;
      end else if (rd_en) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= RP_IDLE;
         inflight_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         inflight_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      len_ff     <= len_in;
      bracket_ff <= bracket_in;
      ovf_ff     <= ovf_in;
      slot_ff    <= slot;
   end

   // result queue
   always_comb begin
      push_data.char_out   = slot_ff.from_mem ? rd_data : slot_ff.ch;
      push_data.char_valid = slot_ff.valid;
      push_data.token_last = slot_ff.last;
      push_data.overflowed = slot_ff.ovf;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = fifo_ff[rd_ptr_ff];

   a_no_queue_overrun: assert property (@(posedge clock) disable iff (reset)
      !((count_ff == 2'd2) && inflight_ff))
      else $error("result queue overrun");

   a_empty_marker_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.char_valid |-> rsp_data.token_last)
      else $error("empty marker without token_last");

endmodule

### sim/qbt_checker.sv
// ----------------------------------------------------------------------------
// qbt_checker
// Watches the tokenizer's request and response channels, predicts each
// response from the accepted bytes and compares it field by field.
// ----------------------------------------------------------------------------
module qbt_checker #(
   parameter int TOKEN_CHARS = qbt_pkg::TOKEN_CHARS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  qbt_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  qbt_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import qbt_pkg::*;

   lex_mode_type mode;
   logic [7:0]   tok_buf [TOKEN_CHARS];
   int           tok_len;
   logic         tok_ovf;
   rsp_type      expected_chars[$];
   int           err_n = 0;

   function automatic bit is_blank(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic void store_char(logic [7:0] c);
      if (tok_len < TOKEN_CHARS) begin
         tok_buf[tok_len] = c;
         tok_len++;
      end else begin
         tok_ovf = 1'b1;
      end
   endfunction

   function automatic void queue_char(logic [7:0] c, logic v, logic last);
      rsp_type r;
      r.char_out   = c;
      r.char_valid = v;
      r.token_last = last;
      r.overflowed = tok_ovf;
      expected_chars = {expected_chars, r};
   endfunction

   // replay the collected token and clear it
   function automatic void flush_token(bit bracketed, bit allow_empty);
      int i;
      if (bracketed) begin
         queue_char(CH_LBRACK, 1'b1, 1'b0);
         for (i = 0; i < tok_len; i++) queue_char(tok_buf[i], 1'b1, 1'b0);
         queue_char(CH_RBRACK, 1'b1, 1'b1);
      end else if (tok_len == 0) begin
         if (allow_empty) queue_char(8'h00, 1'b0, 1'b1);
      end else begin
         for (i = 0; i < tok_len; i++) queue_char(tok_buf[i], 1'b1, i + 1 == tok_len);
      end
      tok_len = 0;
      tok_ovf = 1'b0;
   endfunction

   function automatic void normal_byte(logic [7:0] c);
      if (c == CH_SEMI) begin
         mode = LM_COMMENT;
      end else if (is_blank(c)) begin
         if (tok_len != 0) flush_token(1'b0, 1'b0);
      end else if (c == CH_QUOTE) begin
         mode = LM_QUOTED;
      end else if (c == CH_LBRACK) begin
         mode = LM_BRACKET;
      end else begin
         store_char(c);
      end
   endfunction

   function automatic void lex_byte(req_type it);
      logic [7:0] c;
      c = it.char_in;
      if (it.line_end) begin
         flush_token(1'b0, mode == LM_QPEND);
         mode = LM_NORMAL;
      end else begin
         case (mode)
            LM_QUOTED: begin
               if (c == CH_QUOTE) mode = LM_QPEND;
               else store_char(c);
            end
            LM_QPEND: begin
               if (c == CH_QUOTE) begin
                  store_char(CH_QUOTE);
                  mode = LM_QUOTED;
               end else begin
                  // closing quote confirmed; the byte is lexed fresh
                  flush_token(1'b0, 1'b1);
                  mode = LM_NORMAL;
                  normal_byte(c);
               end
            end
            LM_BRACKET: begin
               if (c == CH_RBRACK) begin
                  flush_token(1'b1, 1'b0);
                  mode = LM_NORMAL;
               end else begin
                  store_char(c);
               end
            end
            LM_COMMENT: ;
            default: begin
               mode = LM_NORMAL;
               normal_byte(c);
            end
         endcase
      end
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", name, want, got);
         err_n++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         mode    = LM_NORMAL;
         tok_len = 0;
         tok_ovf = 1'b0;
         foreach (tok_buf[i]) tok_buf[i] = 8'h00;
         expected_chars.delete();
      end else begin
         // responses first: a byte taken at this edge cannot answer here
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected transfer: char_out %h char_valid %b token_last %b ovf %b",
                      rsp_data.char_out, rsp_data.char_valid, rsp_data.token_last,
                      rsp_data.overflowed);
               err_n++;
            end else begin
               want = expected_chars.pop_front();
               check_field("char_out", want.char_out, rsp_data.char_out);
               check_field("char_valid", want.char_valid, rsp_data.char_valid);
               check_field("token_last", want.token_last, rsp_data.token_last);
               check_field("overflowed", want.overflowed, rsp_data.overflowed);
            end
         end
         if (req_valid && !req_stall) lex_byte(req_data);
      end
      error_count <= err_n;
      outstanding <= expected_chars.size();
   end

endmodule

### sim/tb_quoted_bracket_tokenizer.sv
// ----------------------------------------------------------------------------
// tb_quoted_bracket_tokenizer
// Stimulus and verdict for the quoted/bracketed line tokenizer.
// A few directed lines cover quoting, brackets, comments and unterminated
// spans; then random lines of words, quoted and bracketed spans, comments
// and noise, with random idle bursts on both channels and one long
// response hold-off. qbt_checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_quoted_bracket_tokenizer;
   timeunit 1ns;
   timeprecision 1ps;
   import qbt_pkg::*;

   localparam int RANDOM_ITEMS = 420;
   localparam int CALM_ITEMS   = 50;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AT      = 150;
   localparam int TAIL_CYCLES  = 48;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      error_count;
   int      outstanding;

   req_type line_bytes[$];
   int      live_items = 0;
   int      sent_count = 0;
   bit      calm       = 1'b0;
   bit      held       = 1'b0;

   quoted_bracket_tokenizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   qbt_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   function automatic void put_byte(logic [7:0] c, bit live);
      req_type it;
      it.char_in  = c;
      it.line_end = 1'b0;
      line_bytes = {line_bytes, it};
      if (live) live_items++;
   endfunction

   function automatic void put_end();
      req_type it;
      it.char_in  = 8'($urandom_range(0, 255));
      it.line_end = 1'b1;
      line_bytes = {line_bytes, it};
      live_items++;
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i], 1'b1);
   endfunction

   function automatic logic [7:0] pick_blank();
      logic [7:0] c;
      c = 8'($urandom_range(8, 13));
      return (c == 8'd8) ? 8'd32 : c;
   endfunction

   // any byte that extends an unquoted word
   function automatic logic [7:0] pick_plain();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(0, 255));
      end while (c == 8'd32 || (c >= 8'd9 && c <= 8'd13) || c == CH_SEMI ||
                 c == CH_QUOTE || c == CH_LBRACK);
      return c;
   endfunction

   function automatic logic [7:0] pick_except(logic [7:0] stop);
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(0, 255));
      end while (c == stop);
      return c;
   endfunction

   function automatic void build_line();
      int  n_tok, kind, len;
      bit  done;
      done  = 1'b0;
      n_tok = $urandom_range(1, 5);
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)), 1'b1);
         put_end();
         return;
      end
      repeat (n_tok) begin
         if (!done) begin
            kind = $urandom_range(0, 9);
            len  = ($urandom_range(0, 11) == 0) ? $urandom_range(28, 40)
                                                : $urandom_range(0, 6);
            case (kind)
               0, 1, 2, 3: begin
                  repeat ((len == 0) ? 1 : len) put_byte(pick_plain(), 1'b1);
               end
               4, 5: begin
                  put_byte(CH_QUOTE, 1'b1);
                  repeat (len) begin
                     if ($urandom_range(0, 5) == 0) begin
                        put_byte(CH_QUOTE, 1'b1);
                        put_byte(CH_QUOTE, 1'b1);
                     end else begin
                        put_byte(pick_except(CH_QUOTE), 1'b1);
                     end
                  end
                  if ($urandom_range(0, 11) != 0) put_byte(CH_QUOTE, 1'b1);
               end
               6, 7: begin
                  if ($urandom_range(0, 1) == 0)
                     repeat ($urandom_range(1, 3)) put_byte(pick_plain(), 1'b1);
                  put_byte(CH_LBRACK, 1'b1);
                  repeat (len) put_byte(pick_except(CH_RBRACK), 1'b1);
                  if ($urandom_range(0, 11) != 0) put_byte(CH_RBRACK, 1'b1);
               end
               8: begin
                  put_byte(CH_SEMI, 1'b1);
                  repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(0, 255)), 1'b0);
                  done = 1'b1;
               end
               default: begin
                  repeat ($urandom_range(1, 4)) put_byte(pick_blank(), 1'b1);
               end
            endcase
            // mostly separated; sometimes tokens abut
            if (!done && $urandom_range(0, 7) != 0)
               repeat ($urandom_range(1, 2)) put_byte(pick_blank(), 1'b1);
         end
      end
      put_end();
   endfunction

   // receive side: random stall bursts plus one long hold-off
   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (!held && sent_count >= HOLD_AT) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int base;
      // words with extreme byte values
      put_text("a b");
      put_byte(8'h00, 1'b1);
      put_byte(8'hFF, 1'b1);
      put_end();
      // empty quoted token
      put_text("\"\"");
      put_end();
      // doubled quote, then a comment right after the closing quote
      put_text("\"x\"\"y\";z");
      put_end();
      // prefix moves inside the brackets; semicolon is literal there
      put_text("k[m;]");
      put_end();
      // unterminated quoted and bracketed spans
      put_text("\"u");
      put_end();
      put_text("[v");
      put_end();
      // line ends on the closing quote
      put_text("\"w\"");
      put_end();
      base = live_items;
      while (live_items < base + RANDOM_ITEMS) build_line();

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (line_bytes[i]) begin
         if (i >= line_bytes.size() - CALM_ITEMS) calm <= 1'b1;
         if (!calm && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= line_bytes[i];
         do @(posedge clock); while (req_stall);
         sent_count <= sent_count + 1;
      end
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (outstanding != 0) $error("%0d expected transfers never arrived", outstanding);
      if (error_count == 0 && outstanding == 0) begin
         $display("tb_quoted_bracket_tokenizer OK");
      end else begin
         $display("tb_quoted_bracket_tokenizer NOT OK");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("tb_quoted_bracket_tokenizer NOT OK");
      $finish;
   end

endmodule

### filelist.f
rtl/qbt_pkg.sv
rtl/qbt_tokbuf.sv
rtl/qbt_replay.sv
rtl/quoted_bracket_tokenizer.sv
sim/qbt_checker.sv
sim/tb_quoted_bracket_tokenizer.sv
